// ===== rtl/rsa_pkg.sv =====
package rsa_pkg;

    localparam int unsigned DefaultWidth = 16;

    // register indexes on the configuration port
    localparam logic [1:0] RegModulus    = 2'd0;
    localparam logic [1:0] RegPublicExp  = 2'd1;
    localparam logic [1:0] RegPrivateExp = 2'd2;

    typedef enum logic [2:0] {
        t_idle,
        t_reduce,
        t_square,
        t_mult,
        t_done
    } t_state;

    // control from the sequencer to the cell chain
    typedef struct packed {
        logic load;   // start a modular multiply: load both operands, restart the token
        logic step;   // shift one multiplier bit through the chain
    } t_cell_ctrl;

endpackage

// ===== rtl/rsa_modular_exponentiation_unit.sv =====
// Channel   Dir  Payload
// s_axis    in   tdata {message}, tuser {op}
// m_axis    out  tdata {result}
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data
// Each item first reduces the message, then runs WIDTH squarings plus one
// multiply per set exponent bit, then hands the result off; a new message is
// taken only in idle. When n < 2 the exponent walk is skipped and the result is 0.
// Synchronous active-low reset; registers return to n=2, exponents 1.
// Output register holds the result under stall while the next word is taken.
module rsa_modular_exponentiation_unit #(
    parameter int unsigned WIDTH = rsa_pkg::DefaultWidth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [((WIDTH+7)/8)*8-1:0] s_axis_tdata,   // message
    input  logic               s_axis_tuser,           // op
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [((WIDTH+7)/8)*8-1:0] m_axis_tdata,   // result
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [WIDTH-1:0]   i_cfg_data
);
    import rsa_pkg::*;

    localparam int unsigned CntW = $clog2(WIDTH + 2);
    localparam int unsigned PadW = ((WIDTH+7)/8)*8;

    logic [WIDTH-1:0] r_mod, r_pub, r_priv;
    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_base, r_exp, r_res;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_msg;
    logic [CntW-1:0]  r_cnt;
    logic             r_ovld;
    t_cell_ctrl       w_ctrl;
    logic [WIDTH-1:0] w_prod, w_a, w_b;
    logic             w_take, w_busy;
    logic [WIDTH:0]   w_try;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= WIDTH'(2);
            r_pub  <= WIDTH'(1);
            r_priv <= WIDTH'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegModulus:    r_mod  <= i_cfg_data;
                RegPublicExp:  r_pub  <= i_cfg_data;
                RegPrivateExp: r_priv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_busy = (r_state != t_idle) && (r_state != t_done);
    assign s_axis_tready = (r_state == t_idle);
    assign w_take = s_axis_tvalid && s_axis_tready;
    assign w_try  = {r_rem, r_msg[WIDTH-1]} - {1'b0, r_mod};

    // sequencer; operands of the next multiply come from the product (1 after the reduce, b = base for a multiply)
    always_comb begin
        n_state = r_state;
        w_ctrl  = '0;
        w_a     = w_prod;
        w_b     = w_prod;
        case (r_state)
            t_idle:   if (w_take) n_state = t_reduce;
            t_reduce: begin
                w_a = WIDTH'(1);
                w_b = WIDTH'(1);
                if (r_cnt == CntW'(WIDTH)) begin
                    n_state = (r_mod < WIDTH'(2)) ? t_done : t_square;
                    w_ctrl.load = 1'b1;
                end
            end
            t_square, t_mult: begin
                if (r_cnt == CntW'(WIDTH)) begin
                    if (r_state == t_square && r_exp[WIDTH-1]) begin
                        n_state = t_mult;
                        w_b = r_base;
                        w_ctrl.load = 1'b1;
                    end else if (r_msg == WIDTH'(1)) begin
                        n_state = t_done;
                    end else begin
                        n_state = t_square;
                        w_ctrl.load = 1'b1;
                    end
                end else begin
                    w_ctrl.step = 1'b1;
                end
            end
            t_done:   if (!r_ovld || m_axis_tready) n_state = t_idle;
            default:  n_state = t_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_idle;
        else          r_state <= n_state;
    end

    // datapath: restoring reduce, then exponent walk (r_msg counts bits left)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (r_state)
                t_idle: begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_msg <= s_axis_tdata[WIDTH-1:0];
                    r_exp <= s_axis_tuser ? r_priv : r_pub;
                end
                t_reduce: begin
                    if (r_cnt == CntW'(WIDTH)) begin
                        r_base <= r_rem;
                        r_cnt  <= '0;
                        r_msg  <= WIDTH'(WIDTH);
                        r_res  <= '0;
                    end else begin
                        r_rem <= w_try[WIDTH] ? {r_rem[WIDTH-2:0], r_msg[WIDTH-1]}
                                              : w_try[WIDTH-1:0];
                        r_msg <= {r_msg[WIDTH-2:0], 1'b0};
                        r_cnt <= r_cnt + CntW'(1);
                    end
                end
                t_square, t_mult: begin
                    if (r_cnt == CntW'(WIDTH)) begin
                        r_cnt <= '0;
                        if (!(r_state == t_square && r_exp[WIDTH-1])) begin
                            r_exp <= {r_exp[WIDTH-2:0], 1'b0};
                            r_msg <= r_msg - WIDTH'(1);
                            r_res <= w_prod;
                        end
                    end else begin
                        r_cnt <= r_cnt + CntW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    rsa_chain #(.WIDTH(WIDTH)) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl),
        .i_n    (r_mod),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (r_state == t_done && (!r_ovld || m_axis_tready)) begin
            r_ovld <= 1'b1;
            m_axis_tdata <= PadW'(r_res);
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovld;

    // no new word while the multiplier runs
    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready) else $error("accept while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_done && m_axis_tready) |=> r_state == t_idle) else $error("stuck done");
    a_out_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_done && !r_ovld) |=> r_ovld) else $error("result lost");
endmodule

// ===== rtl/rsa_cell.sv =====
// One cell of the modular multiply chain: one doubling-and-add step,
// acc' = (2*acc + bit*a) mod n, with acc and a both below n.
module rsa_cell #(
    parameter int unsigned WIDTH = rsa_pkg::DefaultWidth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_n,
    input  logic [WIDTH-1:0] i_a,
    input  logic             i_bit,
    input  logic [WIDTH-1:0] i_acc,
    output logic [WIDTH-1:0] o_acc
);
    import rsa_pkg::*;

    logic [WIDTH:0]   w_dbl;
    logic [WIDTH-1:0] w_d;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] r_acc;

    // double, then conditionally add, each reduced by one subtract
    always_comb begin
        w_dbl = {i_acc, 1'b0};
        w_d   = (w_dbl >= {1'b0, i_n}) ? WIDTH'(w_dbl - {1'b0, i_n}) : w_dbl[WIDTH-1:0];
        w_sum = {1'b0, w_d} + (i_bit ? {1'b0, i_a} : '0);
        n_acc = (w_sum >= {1'b0, i_n}) ? WIDTH'(w_sum - {1'b0, i_n}) : w_sum[WIDTH-1:0];
    end

    // hold the partial product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule

// ===== rtl/rsa_chain.sv =====
// Modular multiplier: the multiplier bits enter the cell row MSB first,
// one cell per bit position; the last cell holds the finished product.
module rsa_chain #(
    parameter int unsigned WIDTH = rsa_pkg::DefaultWidth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rsa_pkg::t_cell_ctrl   i_ctrl,
    input  logic [WIDTH-1:0]      i_n,
    input  logic [WIDTH-1:0]      i_a,
    input  logic [WIDTH-1:0]      i_b,
    output logic [WIDTH-1:0]      o_prod
);
    import rsa_pkg::*;

    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] w_acc [WIDTH+1];
    logic [WIDTH-1:0] r_bits;     // valid token per cell
    logic             w_en [WIDTH];

    // hold operands, shift multiplier out MSB first
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (i_ctrl.step) begin
            r_b <= {r_b[WIDTH-2:0], 1'b0};
        end
    end

    // token marks which cell is active this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (i_ctrl.load) begin
            r_bits <= {{(WIDTH-1){1'b0}}, 1'b1};
        end else if (i_ctrl.step) begin
            r_bits <= {r_bits[WIDTH-2:0], 1'b0};
        end
    end

    assign w_acc[0] = '0;

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        assign w_en[g] = i_ctrl.step && r_bits[g];
        rsa_cell #(.WIDTH(WIDTH)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en[g]),
            .i_n    (i_n),
            .i_a    (r_a),
            .i_bit  (r_b[WIDTH-1]),
            .i_acc  (w_acc[g]),
            .o_acc  (w_acc[g+1])
        );
    end

    assign o_prod = w_acc[WIDTH];
endmodule

// ===== tb/sv/rsa_modular_exponentiation_unit_tb.sv =====
`timescale 1ns / 100ps

module rsa_modular_exponentiation_unit_tb;
    import rsa_pkg::*;

    localparam int unsigned W = 16;
    localparam int unsigned DATA_W = ((W + 7) / 8) * 8;
    localparam int unsigned STALL_LIMIT = 20000;

    // expected results of the modular exponentiation, in word order
    class modexp_board;
        logic [W-1:0] modulus_r;
        logic [W-1:0] pub_exp_r;
        logic [W-1:0] priv_exp_r;
        logic [W-1:0] expected_q[$];
        int           mismatches;

        function new();
            modulus_r  = 2;
            pub_exp_r  = 1;
            priv_exp_r = 1;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [W-1:0] val);
            case (idx)
                RegModulus:    modulus_r  = val;
                RegPublicExp:  pub_exp_r  = val;
                RegPrivateExp: priv_exp_r = val;
                default: ;
            endcase
        endfunction

        // square-and-multiply on the reduced message
        function logic [W-1:0] power_mod(logic op, logic [W-1:0] msg);
            longint unsigned n;
            longint unsigned base;
            longint unsigned acc;
            logic [W-1:0]    e;
            n = modulus_r;
            if (n < 2) return '0;
            e = op ? priv_exp_r : pub_exp_r;
            base = msg % n;
            acc = 1;
            for (int i = W - 1; i >= 0; i--) begin
                acc = (acc * acc) % n;
                if (e[i]) acc = (acc * base) % n;
            end
            return acc[W-1:0];
        endfunction

        function void note_word(logic op, logic [W-1:0] msg);
            expected_q.push_back(power_mod(op, msg));
        endfunction

        function void check_word(logic [W-1:0] actual);
            logic [W-1:0] want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %0d", actual);
                return;
            end
            want = expected_q.pop_front();
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %0d, got %0d", want, actual);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;   // message
    logic              s_axis_tuser;   // op
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;   // result
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [W-1:0]      i_cfg_data;

    modexp_board sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    rsa_modular_exponentiation_unit #(.WIDTH(W)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // drain results with random backpressure
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata[W-1:0]);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("rsa_modular_exponentiation_unit verification failed");
            $finish;
        end
    end

    // write all three registers back to back; block must be idle
    task automatic configure(logic [W-1:0] n, logic [W-1:0] pe, logic [W-1:0] de);
        logic [W-1:0] vals[3];
        vals = '{n, pe, de};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_reg(2'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // offer one word, with a random gap ahead of it; tvalid stays up after
    task automatic send_word(logic op, logic [W-1:0] msg);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(msg);
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(op, msg);
    endtask

    // hold off until every expected result is back, then settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        logic [W-1:0] n;
        logic [W-1:0] pe;
        logic [W-1:0] de;
        logic [W-1:0] corner_msgs[4];
        corner_msgs   = '{16'd0, 16'd1, 16'hFFFE, 16'hFFFF};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= RegModulus;
        i_cfg_data    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: n=2, exponents 1
        send_word(1'b0, 16'd0);
        send_word(1'b1, 16'hFFFF);
        send_word(1'b0, 16'd3);
        drain();
        // widest modulus, largest and zero exponents
        configure(16'hFFFF, 16'hFFFF, 16'd0);
        foreach (corner_msgs[i]) begin
            send_word(1'b0, corner_msgs[i]);
            send_word(1'b1, corner_msgs[i]);
        end
        drain();
        // exponent of one still reduces the message
        configure(16'd251, 16'd1, 16'd2);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b1, 16'd500);
        send_word(1'b0, 16'd251);
        drain();
        // degenerate moduli give zero
        configure(16'd0, 16'd5, 16'd0);
        send_word(1'b0, 16'd7);
        send_word(1'b1, 16'hFFFF);
        drain();
        configure(16'd1, 16'd0, 16'd3);
        send_word(1'b0, 16'd9);
        send_word(1'b1, 16'd0);
        drain();

        // random phases: sender 28 / receiver 49, then swapped, then none
        for (int ph = 0; ph < 12; ph++) begin
            send_idle_pct = (ph < 4) ? 28 : (ph < 8) ? 49 : 0;
            recv_idle_pct = (ph < 4) ? 49 : (ph < 8) ? 28 : 0;
            case (ph)
                0:  begin n = 16'hFFFF; pe = 16'hFFFF; de = 16'd0; end
                1:  begin n = 16'd2;    pe = 16'd0;    de = 16'hFFFF; end
                5:  begin n = 16'd3233; pe = 16'd17;   de = 16'd2753; end
                9:  begin n = 16'd0;    pe = 16'd1;    de = 16'd1; end
                default: begin
                    n  = 16'($urandom_range(65535, 2));
                    pe = 16'($urandom);
                    de = 16'($urandom);
                end
            endcase
            configure(n, pe, de);
            for (int k = 0; k < ((ph == 9) ? 20 : 103); k++) begin
                send_word(1'($urandom), 16'($urandom));
                // pause mid-phase until all results are back
                if (k == 50 && ph == 2) drain();
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("rsa_modular_exponentiation_unit verification clean");
        else
            $display("rsa_modular_exponentiation_unit verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rsa_pkg.sv
rtl/rsa_cell.sv
rtl/rsa_chain.sv
rtl/rsa_modular_exponentiation_unit.sv
tb/sv/rsa_modular_exponentiation_unit_tb.sv
